[rtl/pcr_pkg.sv]
package pcr_pkg;

   // Port widths fixed by the interface.
   localparam int VEC_W  = 63;
   localparam int MASS_W = 20;
   localparam int PEN_W  = 21;
   localparam int REST_W = 13;

   // Defaults for the top-level parameters.
   localparam int COMPONENT_BITS_DEF = 21;
   localparam int FRAC_BITS_DEF      = 12;

   // Restitution is unsigned Q1.12; the factor (1 + e) needs one more bit.
   localparam int REST_FRAC = 12;
   localparam int REST_ONE  = 4096;
   localparam int EF_W      = REST_W + 1;

   // Quotient bits resolved per divider stage.
   localparam int DIV_STEPS_DEF = 4;

endpackage

[rtl/pcr_div.sv]
// Pipelined restoring divider with two lanes sharing one divisor.
// Each stage resolves STEPS quotient bits; side data travels alongside.
module pcr_div #(
   parameter int NW     = 53,
   parameter int DW     = 21,
   parameter int STEPS  = pcr_pkg::DIV_STEPS_DEF,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     num_a,
   input  logic [NW-1:0]     num_b,
   input  logic [DW-1:0]     den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NW-1:0]     quot_a,
   output logic [DW-1:0]     rem_a,
   output logic [NW-1:0]     quot_b,
   output logic [SIDE_W-1:0] side_out
);

   localparam int STAGES = (NW + STEPS - 1) / STEPS;
   localparam int NP     = STAGES * STEPS;
   localparam int RW     = DW + 1;

   logic              v_ff    [STAGES];
   logic [RW-1:0]     ra_ff   [STAGES];
   logic [RW-1:0]     rb_ff   [STAGES];
   logic [NP-1:0]     na_ff   [STAGES];
   logic [NP-1:0]     nb_ff   [STAGES];
   logic [DW-1:0]     den_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              v_src;
      logic [RW-1:0]     ra_src, rb_src, ra_in, rb_in;
      logic [NP-1:0]     na_src, nb_src, na_in, nb_in;
      logic [DW-1:0]     den_src;
      logic [SIDE_W-1:0] side_src;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign ra_src   = '0;
         assign rb_src   = '0;
         assign na_src   = NP'(num_a);
         assign nb_src   = NP'(num_b);
         assign den_src  = den;
         assign side_src = side_in;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign ra_src   = ra_ff[s-1];
         assign rb_src   = rb_ff[s-1];
         assign na_src   = na_ff[s-1];
         assign nb_src   = nb_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // The dividend shifts out at the top while quotient bits enter at the bottom.
      always_comb begin
         ra_in = ra_src;
         rb_in = rb_src;
         na_in = na_src;
         nb_in = nb_src;
         for (int k = 0; k < STEPS; k++) begin
            ra_in = {ra_in[RW-2:0], na_in[NP-1]};
            na_in = {na_in[NP-2:0], 1'b0};
            if (ra_in >= {1'b0, den_src}) begin
               ra_in    = ra_in - {1'b0, den_src};
               na_in[0] = 1'b1;
            end
            rb_in = {rb_in[RW-2:0], nb_in[NP-1]};
            nb_in = {nb_in[NP-2:0], 1'b0};
            if (rb_in >= {1'b0, den_src}) begin
               rb_in    = rb_in - {1'b0, den_src};
               nb_in[0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
         if (en) begin
            ra_ff[s]   <= ra_in;
            rb_ff[s]   <= rb_in;
            na_ff[s]   <= na_in;
            nb_ff[s]   <= nb_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign quot_a    = na_ff[STAGES-1][NW-1:0];
   assign rem_a     = ra_ff[STAGES-1][DW-1:0];
   assign quot_b    = nb_ff[STAGES-1][NW-1:0];
   assign side_out  = side_ff[STAGES-1];

endmodule

[rtl/particle_contact_resolver.sv]
// Two-particle contact resolver. Each request beat carries both positions,
// both velocities, the contact normal, both inverse masses and the penetration
// depth; each produces exactly one response beat, in order. A new contact is
// taken every cycle unless the pipeline is halted. NW is the width of the
// impulse dividend (3*COMPONENT_BITS + 2 - FRAC_BITS bits, 53 with the
// default widths), which passes through the
// pipelined restoring divider, which resolves four quotient bits per stage and
// splits both the impulse and the penetration by inverse-mass ratio. The whole
// pipeline halts together while a response beat is held by rsp_stall, so
// req_stall is raised in the same cycle. The restitution register is
// written through the csr_ port, which is always ready, and must only be
// written while no contact is in flight. Every output component is saturated
// to its signed range; when both inverse masses are zero the vectors pass
// through unchanged and both_immovable is raised.
module particle_contact_resolver #(
   parameter int COMPONENT_BITS = pcr_pkg::COMPONENT_BITS_DEF,
   parameter int FRAC_BITS      = pcr_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pcr_pkg::REST_W-1:0]  csr_restitution,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pcr_pkg::VEC_W-1:0]   req_pos_a,
   input  logic [pcr_pkg::VEC_W-1:0]   req_pos_b,
   input  logic [pcr_pkg::VEC_W-1:0]   req_vel_a,
   input  logic [pcr_pkg::VEC_W-1:0]   req_vel_b,
   input  logic [pcr_pkg::VEC_W-1:0]   req_contact_normal,
   input  logic [pcr_pkg::MASS_W-1:0]  req_inv_mass_a,
   input  logic [pcr_pkg::MASS_W-1:0]  req_inv_mass_b,
   input  logic signed [pcr_pkg::PEN_W-1:0] req_penetration,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pcr_pkg::VEC_W-1:0]   rsp_new_pos_a,
   output logic [pcr_pkg::VEC_W-1:0]   rsp_new_pos_b,
   output logic [pcr_pkg::VEC_W-1:0]   rsp_new_vel_a,
   output logic [pcr_pkg::VEC_W-1:0]   rsp_new_vel_b,
   output logic                        rsp_impulse_applied,
   output logic                        rsp_both_immovable
);

   // Internal widths, all following from the component format.
   localparam int C    = COMPONENT_BITS;
   localparam int F    = FRAC_BITS;
   localparam int VW   = 3 * C;
   localparam int IMW  = C - 1;                 // usable inverse-mass bits
   localparam int MW   = 2 * C + 1;             // (va - vb) * n
   localparam int SW   = 2 * C + 2;             // closing speed at scale 2F
   localparam int PMW  = 2 * C - 1;             // |pen| * ima
   localparam int EW   = pcr_pkg::EF_W;
   localparam int PRW  = SW - 1 + EW;           // speed * (1 + e)
   localparam int PW   = PRW - pcr_pkg::REST_FRAC - F;
   localparam int NWA  = PW + IMW;
   localparam int NW   = (NWA > PMW) ? NWA : PMW;
   localparam int KW   = C + PW + 1;            // n * k, also the sum width
   localparam int PPW  = 2 * C + 1;             // n * disp

   typedef struct packed {
      logic [VW-1:0]         pa;
      logic [VW-1:0]         pb;
      logic [VW-1:0]         va;
      logic [VW-1:0]         vb;
      logic [VW-1:0]         n;
      logic signed [C-1:0]   pen;
      logic [IMW-1:0]        ima;
      logic [C-1:0]          ims;
      logic                  imm;
   } base_type;

   localparam int SIDE_W = $bits(base_type) + PW + 1;

   // The whole pipeline moves unless a finished beat is being held.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Restitution register.
   logic [pcr_pkg::REST_W-1:0] rest_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         rest_ff <= csr_restitution;
      end
   end

   // Stage 1: capture the beat, masked to the component format.
   base_type b1_in, b1_ff;
   logic     v1_ff;

   always_comb begin
      b1_in.pa  = req_pos_a[VW-1:0];
      b1_in.pb  = req_pos_b[VW-1:0];
      b1_in.va  = req_vel_a[VW-1:0];
      b1_in.vb  = req_vel_b[VW-1:0];
      b1_in.n   = req_contact_normal[VW-1:0];
      b1_in.pen = req_penetration[C-1:0];
      b1_in.ima = req_inv_mass_a[IMW-1:0];
      b1_in.ims = C'(req_inv_mass_a[IMW-1:0]) + C'(req_inv_mass_b[IMW-1:0]);
      b1_in.imm = (b1_in.ims == '0);
   end

   // Stage 2: relative velocity and penetration magnitude.
   base_type               b2_ff;
   logic                   v2_ff;
   logic signed [C:0]      d2_in [3];
   logic signed [C:0]      d2_ff [3];
   logic [C-1:0]           pm2_in, pm2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d2_in[i] = (C+1)'($signed(b1_ff.va[i*C +: C]))
                  - (C+1)'($signed(b1_ff.vb[i*C +: C]));
      end
      // Negating the most negative value wraps to its correct unsigned magnitude.
      pm2_in = b1_ff.pen[C-1] ? C'(-b1_ff.pen) : C'(b1_ff.pen);
   end

   // Stage 3: the three dot-product terms and |pen| * ima.
   base_type               b3_ff;
   logic                   v3_ff;
   logic signed [MW-1:0]   m3_in [3];
   logic signed [MW-1:0]   m3_ff [3];
   logic [PMW-1:0]         pim3_in, pim3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m3_in[i] = MW'(d2_ff[i]) * MW'($signed(b2_ff.n[i*C +: C]));
      end
      pim3_in = PMW'(pm2_ff) * PMW'(b2_ff.ima);
   end

   // Stage 4: closing speed, taken against the negated normal.
   base_type               b4_ff;
   logic                   v4_ff;
   logic signed [SW-1:0]   s4_in, s4_ff;
   logic [PMW-1:0]         pim4_ff;

   always_comb begin
      s4_in = -(SW'(m3_ff[0]) + SW'(m3_ff[1]) + SW'(m3_ff[2]));
   end

   // Stage 5: scale by (1 + e) when the particles are closing and movable.
   base_type               b5_ff;
   logic                   v5_ff;
   logic                   hit5_in, hit5_ff;
   logic [PRW-1:0]         pr5_in, pr5_ff;
   logic [PMW-1:0]         pim5_ff;
   logic [EW-1:0]          ef;

   always_comb begin
      ef      = EW'(pcr_pkg::REST_ONE) + EW'(rest_ff);
      hit5_in = !s4_ff[SW-1] && (s4_ff != '0) && !b4_ff.imm;
      pr5_in  = hit5_in ? PRW'(s4_ff[SW-2:0]) * PRW'(ef) : '0;
   end

   // Stage 6: impulse dividend P * ima.
   base_type               b6_ff;
   logic                   v6_ff;
   logic                   hit6_ff;
   logic [PW-1:0]          p6_in, p6_ff;
   logic [NW-1:0]          na6_in, na6_ff;
   logic [NW-1:0]          nb6_ff;

   always_comb begin
      p6_in  = pr5_ff[PRW-1 -: PW];
      na6_in = NW'(p6_in) * NW'(b5_ff.ima);
   end

   // Divider: both splits are divided by ima + imb in the same pipeline.
   logic              dv_valid;
   logic [NW-1:0]     dv_qa, dv_qb;
   logic [C-1:0]      dv_ra;
   logic [SIDE_W-1:0] dv_side;
   base_type          bd;
   logic              hitd;
   logic [PW-1:0]     pd;

   pcr_div #(
      .NW     (NW),
      .DW     (C),
      .STEPS  (pcr_pkg::DIV_STEPS_DEF),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .num_a     (na6_ff),
      .num_b     (nb6_ff),
      .den       (b6_ff.ims),
      .side_in   ({hit6_ff, p6_ff, b6_ff}),
      .out_valid (dv_valid),
      .quot_a    (dv_qa),
      .rem_a     (dv_ra),
      .quot_b    (dv_qb),
      .side_out  (dv_side)
   );

   assign {hitd, pd, bd} = dv_side;

   // Stage 7: impulse shares and signed displacements.
   // floor(P*imb/ims) is P - ka, less one when the division left a remainder.
   base_type               b7_ff;
   logic                   v7_ff;
   logic                   hit7_ff;
   logic [PW-1:0]          ka7_in, ka7_ff, kb7_in, kb7_ff;
   logic signed [C:0]      da7_in, da7_ff, db7_in, db7_ff;
   logic [C-1:0]           mag7;

   always_comb begin
      if (hitd) begin
         ka7_in = dv_qa[PW-1:0];
         kb7_in = pd - dv_qa[PW-1:0] - PW'(dv_ra != '0);
      end else begin
         ka7_in = '0;
         kb7_in = '0;
      end
      mag7 = dv_qb[C-1:0];
      if (bd.imm) begin
         da7_in = '0;
         db7_in = '0;
      end else begin
         da7_in = bd.pen[C-1] ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
         db7_in = (C+1)'(bd.pen) - da7_in;
      end
   end

   // Stage 8: the twelve corrections along the normal.
   base_type               b8_ff;
   logic                   v8_ff;
   logic                   hit8_ff;
   logic signed [KW-1:0]   va8_in [3], va8_ff [3], vb8_in [3], vb8_ff [3];
   logic signed [PPW-1:0]  pa8_in [3], pa8_ff [3], pb8_in [3], pb8_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va8_in[i] = KW'($signed(b7_ff.n[i*C +: C])) * $signed(KW'(ka7_ff));
         vb8_in[i] = KW'($signed(b7_ff.n[i*C +: C])) * $signed(KW'(kb7_ff));
         pa8_in[i] = PPW'($signed(b7_ff.n[i*C +: C])) * PPW'(da7_ff);
         pb8_in[i] = PPW'($signed(b7_ff.n[i*C +: C])) * PPW'(db7_ff);
      end
   end

   // Stage 9: drop the fraction, rounding toward zero.
   base_type               b9_ff;
   logic                   v9_ff;
   logic                   hit9_ff;
   logic signed [KW-1:0]   va9_in [3], va9_ff [3], vb9_in [3], vb9_ff [3];
   logic signed [KW-1:0]   pa9_in [3], pa9_ff [3], pb9_in [3], pb9_ff [3];

   always_comb begin
      logic signed [KW-1:0]  kbias;
      logic signed [PPW-1:0] pbias;
      logic signed [KW-1:0]  kx;
      logic signed [PPW-1:0] px;
      kbias = $signed({{(KW-F){1'b0}}, {F{1'b1}}});
      pbias = $signed({{(PPW-F){1'b0}}, {F{1'b1}}});
      for (int i = 0; i < 3; i++) begin
         kx        = va8_ff[i] + (va8_ff[i][KW-1] ? kbias : KW'(0));
         va9_in[i] = kx >>> F;
         kx        = vb8_ff[i] + (vb8_ff[i][KW-1] ? kbias : KW'(0));
         vb9_in[i] = kx >>> F;
         px        = pa8_ff[i] + (pa8_ff[i][PPW-1] ? pbias : PPW'(0));
         pa9_in[i] = KW'(px >>> F);
         px        = pb8_ff[i] + (pb8_ff[i][PPW-1] ? pbias : PPW'(0));
         pb9_in[i] = KW'(px >>> F);
      end
   end

   // Stage 10: apply, saturate and pack into the response register.
   logic [VW-1:0] npa_in, npb_in, nva_in, nvb_in;
   logic          out_valid_ff;
   logic [pcr_pkg::VEC_W-1:0] npa_ff, npb_ff, nva_ff, nvb_ff;
   logic          imp_ff, imm_ff;

   always_comb begin
      logic signed [KW-1:0] sum [4];
      logic [C-1:0]         res [4];
      for (int i = 0; i < 3; i++) begin
         sum[0] = KW'($signed(b9_ff.pa[i*C +: C])) + pa9_ff[i];
         sum[1] = KW'($signed(b9_ff.pb[i*C +: C])) - pb9_ff[i];
         sum[2] = KW'($signed(b9_ff.va[i*C +: C])) + va9_ff[i];
         sum[3] = KW'($signed(b9_ff.vb[i*C +: C])) - vb9_ff[i];
         for (int j = 0; j < 4; j++) begin
            // In range when every bit from the component sign upwards agrees.
            if ((sum[j][KW-1:C-1] == '0) || (sum[j][KW-1:C-1] == '1)) begin
               res[j] = sum[j][C-1:0];
            end else if (sum[j][KW-1]) begin
               res[j] = {1'b1, {(C-1){1'b0}}};
            end else begin
               res[j] = {1'b0, {(C-1){1'b1}}};
            end
         end
         npa_in[i*C +: C] = res[0];
         npb_in[i*C +: C] = res[1];
         nva_in[i*C +: C] = res[2];
         nvb_in[i*C +: C] = res[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= dv_valid;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         out_valid_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_ff   <= b1_in;
         b2_ff   <= b1_ff;
         d2_ff   <= d2_in;
         pm2_ff  <= pm2_in;
         b3_ff   <= b2_ff;
         m3_ff   <= m3_in;
         pim3_ff <= pim3_in;
         b4_ff   <= b3_ff;
         s4_ff   <= s4_in;
         pim4_ff <= pim3_ff;
         b5_ff   <= b4_ff;
         hit5_ff <= hit5_in;
         pr5_ff  <= pr5_in;
         pim5_ff <= pim4_ff;
         b6_ff   <= b5_ff;
         hit6_ff <= hit5_ff;
         p6_ff   <= p6_in;
         na6_ff  <= na6_in;
         nb6_ff  <= NW'(pim5_ff);
         b7_ff   <= bd;
         hit7_ff <= hitd;
         ka7_ff  <= ka7_in;
         kb7_ff  <= kb7_in;
         da7_ff  <= da7_in;
         db7_ff  <= db7_in;
         b8_ff   <= b7_ff;
         hit8_ff <= hit7_ff;
         va8_ff  <= va8_in;
         vb8_ff  <= vb8_in;
         pa8_ff  <= pa8_in;
         pb8_ff  <= pb8_in;
         b9_ff   <= b8_ff;
         hit9_ff <= hit8_ff;
         va9_ff  <= va9_in;
         vb9_ff  <= vb9_in;
         pa9_ff  <= pa9_in;
         pb9_ff  <= pb9_in;
         npa_ff  <= pcr_pkg::VEC_W'(npa_in);
         npb_ff  <= pcr_pkg::VEC_W'(npb_in);
         nva_ff  <= pcr_pkg::VEC_W'(nva_in);
         nvb_ff  <= pcr_pkg::VEC_W'(nvb_in);
         imp_ff  <= hit9_ff;
         imm_ff  <= b9_ff.imm;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_new_pos_a       = npa_ff;
   assign rsp_new_pos_b       = npb_ff;
   assign rsp_new_vel_a       = nva_ff;
   assign rsp_new_vel_b       = nvb_ff;
   assign rsp_impulse_applied = imp_ff;
   assign rsp_both_immovable  = imm_ff;

`ifndef SYNTHESIS
   // An immovable pair can never receive an impulse.
   a_imm_no_impulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_both_immovable |-> !rsp_impulse_applied)
      else $error("impulse reported for an immovable pair");

   // While the response is held, no beat moves anywhere in the pipeline.
   a_hold_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff,
                       v7_ff, v8_ff, v9_ff}))
      else $error("pipeline advanced during a hold");

   // Both quotients fit their narrow result fields for a movable pair.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      dv_valid && !bd.imm |-> (dv_qa[NW-1:PW] == '0) && (dv_qb[NW-1:C] == '0))
      else $error("divider quotient out of range");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
